// ----- hdl/aes_pkg.sv -----
package aes_pkg;

    localparam int RK_DEPTH = 60;
    localparam int RK_AW    = 6;

    localparam logic [2:0] CFG_KEY_MODE = 3'd0;
    localparam logic [2:0] CFG_KEY_0    = 3'd1;
    localparam logic [2:0] CFG_KEY_1    = 3'd2;
    localparam logic [2:0] CFG_KEY_2    = 3'd3;
    localparam logic [2:0] CFG_KEY_3    = 3'd4;

    localparam logic [1:0] MODE_128 = 2'd0;
    localparam logic [1:0] MODE_192 = 2'd1;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_EXPAND,
        ST_PRIME,
        ST_RUN
    } state_t;

    typedef enum logic [1:0] {
        KIND_INIT,
        KIND_MID,
        KIND_LAST
    } col_kind_t;

    typedef struct packed {
        logic             we;
        logic [RK_AW-1:0] addr;
        logic [31:0]      data;
    } key_wr_t;

    localparam logic [2047:0] SBOX_BITS = 2048'h
637c777bf26b6fc53001672bfed7ab76ca82c97dfa5947f0add4a2af9ca472c0b7fd9326363ff7cc34a5e5f171d83115_04c723c31896059a071280e2eb27b27509832c1a1b6e5aa0523bd6b329e32f8453d100ed20fcb15b6acbbe394a4c58cf_d0efaafb434d338545f9027f503c9fa851a3408f929d38f5bcb6da2110fff3d2cd0c13ec5f974417c4a77e3d645d1973_60814fdc222a908846eeb814de5e0bdbe0323a0a4906245cc2d3ac629195e479e7c8376d8dd54ea96c56f4ea657aae08_ba78252e1ca6b4c6e8dd741f4bbd8b8a703eb5664803f60e613557b986c11d9ee1f8981169d98e949b1e87e9ce5528df_8ca1890dbfe6426841992d0fb054bb16;

    localparam logic [2047:0] INV_SBOX_BITS = 2048'h
52096ad53036a538bf40a39e81f3d7fb7ce339829b2fff87348e4344c4dee9cb547b9432a6c2233dee4c950b42fac34e_082ea16628d924b2765ba2496d8bd12572f8f66486689816d4a45ccc5d65b6926c704850fdedb9da5e154657a78d9d84_90d8ab008cbcd30af7e45805b8b34506d02c1e8fca3f0f02c1afbd0301138a6b3a9111414f67dcea97f2cfcef0b4e673_96ac7422e7ad3585e2f937e81c75df6e47f11a711d29c5896fb7620eaa18be1bfc563e4bc6d279209adbc0fe78cd5af4_1fdda8338807c731b11210592780ec5f60517fa919b54a0d2de57a9f93c99cefa0e03b4dae2af5b0c8ebbb3c83539961_172b047eba77d626e169146355210c7d;

    function automatic logic [7:0] sbox(input logic [7:0] x);
        return SBOX_BITS[{~x, 3'b000} +: 8];
    endfunction

    function automatic logic [7:0] inv_sbox(input logic [7:0] x);
        return INV_SBOX_BITS[{~x, 3'b000} +: 8];
    endfunction

    function automatic logic [31:0] sub_word(input logic [31:0] w);
        return {sbox(w[31:24]), sbox(w[23:16]), sbox(w[15:8]), sbox(w[7:0])};
    endfunction

    function automatic logic [7:0] xt(input logic [7:0] b);
        return {b[6:0], 1'b0} ^ (b[7] ? 8'h1B : 8'h00);
    endfunction

    // byte r of the word sits at bits 31-8r
    function automatic logic [31:0] mix_col(input logic [31:0] w);
        logic [3:0][7:0] a;
        logic [3:0][7:0] d;
        logic [3:0][7:0] o;
        a = {w[7:0], w[15:8], w[23:16], w[31:24]};
        for (int r = 0; r < 4; r++)
        begin
            d[r] = xt(a[r]);
        end
        for (int r = 0; r < 4; r++)
        begin
            o[r] = d[r] ^ d[(r + 1) % 4] ^ a[(r + 1) % 4] ^ a[(r + 2) % 4] ^ a[(r + 3) % 4];
        end
        return {o[0], o[1], o[2], o[3]};
    endfunction

    function automatic logic [31:0] inv_mix_col(input logic [31:0] w);
        logic [3:0][7:0] a;
        logic [3:0][7:0] x2;
        logic [3:0][7:0] x4;
        logic [3:0][7:0] x8;
        logic [3:0][7:0] m9;
        logic [3:0][7:0] mb;
        logic [3:0][7:0] md;
        logic [3:0][7:0] me;
        logic [3:0][7:0] o;
        a = {w[7:0], w[15:8], w[23:16], w[31:24]};
        for (int r = 0; r < 4; r++)
        begin
            x2[r] = xt(a[r]);
            x4[r] = xt(x2[r]);
            x8[r] = xt(x4[r]);
            m9[r] = x8[r] ^ a[r];
            mb[r] = x8[r] ^ x2[r] ^ a[r];
            md[r] = x8[r] ^ x4[r] ^ a[r];
            me[r] = x8[r] ^ x4[r] ^ x2[r];
        end
        for (int r = 0; r < 4; r++)
        begin
            o[r] = me[r] ^ mb[(r + 1) % 4] ^ md[(r + 2) % 4] ^ m9[(r + 3) % 4];
        end
        return {o[0], o[1], o[2], o[3]};
    endfunction

endpackage

// ----- hdl/aes_block_cipher.sv -----
// channel   | ports                                   | handshake
// ----------+-----------------------------------------+--------------------------
// command   | op, block_high, block_low               | start & !busy
// result    | result_high, result_low                 | result_valid, one cycle
// config    | cfg_index, cfg_data                     | cfg_we, no wait
// One column of one round per cycle through a shared S-box/MixColumns unit:
// a block runs the initial key addition and Nr rounds, column by column, to result_valid.
// After reset or any key or mode write the first block also runs key expansion,
// one round-key word per cycle.
// Reset is asynchronous, active low; the round-key store needs no clearing.
// busy is high from the cycle after start until the result word is shown;
// result_valid is high for one cycle only, the receiver cannot stall it.
module aes_block_cipher (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    output logic        busy,
    input  logic        op,
    input  logic [63:0] block_high,
    input  logic [63:0] block_low,
    output logic        result_valid,
    output logic [63:0] result_high,
    output logic [63:0] result_low,
    input  logic        cfg_we,
    input  logic [2:0]  cfg_index,
    input  logic [63:0] cfg_data
);
    import aes_pkg::*;

    state_t           state_reg;
    state_t           state_next;
    logic [1:0]       mode_reg;
    logic [3:0][63:0] key_reg;
    logic             sched_valid_reg;
    logic             op_reg;
    logic [3:0]       nr_reg;
    logic [5:0]       step_reg;
    logic [5:0]       step_next;
    logic [127:0]     cur_reg;
    logic [127:0]     nxt_reg;
    logic [31:0]      rk_mem [RK_DEPTH];
    logic [31:0]      rk_rd_reg;
    logic             result_valid_reg;
    logic [127:0]     result_reg;

    logic             accept;
    logic             exp_go;
    logic             exp_done;
    key_wr_t          exp_wr;
    logic [5:0]       rd_step;
    logic [RK_AW-1:0] rd_addr;
    logic             last_step;
    col_kind_t        kind;
    logic [31:0]      col_out;
    logic [3:0]       nr_sel;

    assign accept    = start && !busy;
    assign busy      = state_reg != ST_IDLE;
    assign exp_go    = accept && !sched_valid_reg;
    assign last_step = step_reg == {nr_reg, 2'b11};

    always_comb
    begin
        unique case (mode_reg)
            MODE_128: nr_sel = 4'd10;
            MODE_192: nr_sel = 4'd12;
            default:  nr_sel = 4'd14;
        endcase
    end

    aes_key_exp u_key_exp (
        .clk   (clk),
        .rst_n (rst_n),
        .go    (exp_go),
        .mode  (mode_reg),
        .key   (key_reg),
        .wr    (exp_wr),
        .done  (exp_done)
    );

    // fetch the key word one step ahead; decryption walks rounds backward
    always_comb
    begin
        if (state_reg == ST_RUN && !last_step)
        begin
            rd_step = step_reg + 6'd1;
        end
        else
        begin
            rd_step = '0;
        end
        rd_addr = op_reg ? {4'(nr_reg - rd_step[5:2]), rd_step[1:0]} : rd_step;
    end

    always_ff @(posedge clk)
    begin
        if (exp_wr.we)
        begin
            rk_mem[exp_wr.addr] <= exp_wr.data;
        end
        rk_rd_reg <= rk_mem[rd_addr];
    end

    always_comb
    begin
        if (step_reg[5:2] == 4'd0)
        begin
            kind = KIND_INIT;
        end
        else if (step_reg[5:2] == nr_reg)
        begin
            kind = KIND_LAST;
        end
        else
        begin
            kind = KIND_MID;
        end
    end

    aes_col_unit u_col (
        .state    (cur_reg),
        .col      (step_reg[1:0]),
        .op       (op_reg),
        .kind     (kind),
        .key_word (rk_rd_reg),
        .col_out  (col_out)
    );

    always_comb
    begin
        state_next = state_reg;
        step_next  = step_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    state_next = sched_valid_reg ? ST_PRIME : ST_EXPAND;
                end
            end
            ST_EXPAND:
            begin
                if (exp_done)
                begin
                    state_next = ST_PRIME;
                end
            end
            ST_PRIME:
            begin
                state_next = ST_RUN;
                step_next  = '0;
            end
            ST_RUN:
            begin
                step_next = step_reg + 6'd1;
                if (last_step)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= ST_IDLE;
            step_reg         <= '0;
            mode_reg         <= MODE_128;
            key_reg          <= '0;
            sched_valid_reg  <= 1'b0;
            result_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg        <= state_next;
            step_reg         <= step_next;
            result_valid_reg <= state_reg == ST_RUN && last_step;
            if (exp_done)
            begin
                sched_valid_reg <= 1'b1;
            end
            if (cfg_we)
            begin
                unique case (cfg_index)
                    CFG_KEY_MODE:
                    begin
                        mode_reg        <= cfg_data[1:0];
                        sched_valid_reg <= 1'b0;
                    end
                    CFG_KEY_0, CFG_KEY_1, CFG_KEY_2, CFG_KEY_3:
                    begin
                        key_reg[2'(cfg_index - CFG_KEY_0)] <= cfg_data;
                        sched_valid_reg                    <= 1'b0;
                    end
                    default:
                    begin
                    end
                endcase
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            op_reg  <= op;
            nr_reg  <= nr_sel;
            cur_reg <= {block_high, block_low};
        end
        else if (state_reg == ST_RUN)
        begin
            nxt_reg[{~step_reg[1:0], 5'b0} +: 32] <= col_out;
            if (step_reg[1:0] == 2'b11)
            begin
                cur_reg <= {nxt_reg[127:32], col_out};
            end
            if (last_step)
            begin
                result_reg <= {nxt_reg[127:32], col_out};
            end
        end
    end

    assign result_valid = result_valid_reg;
    assign result_high  = result_reg[127:64];
    assign result_low   = result_reg[63:0];

    a_result_after_run: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid |-> $past(state_reg) == ST_RUN)
        else $error("result word without a finished round sequence");

    a_run_needs_schedule: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_RUN || state_reg == ST_PRIME) |-> sched_valid_reg)
        else $error("rounds running on a stale key schedule");

    a_start_goes_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |=> busy)
        else $error("accepted word did not raise busy");

    a_expand_only_when_stale: assert property (@(posedge clk) disable iff (!rst_n)
        exp_wr.we |-> (state_reg == ST_EXPAND && !sched_valid_reg))
        else $error("key store written outside expansion");

endmodule

// ----- hdl/aes_col_unit.sv -----
module aes_col_unit (
    input  logic [127:0]             state,
    input  logic [1:0]               col,
    input  logic                     op,
    input  aes_pkg::col_kind_t       kind,
    input  logic [31:0]              key_word,
    output logic [31:0]              col_out
);
    import aes_pkg::*;

    logic [31:0] sb_fwd;
    logic [31:0] sb_inv;
    logic [31:0] own_col;

    // forward shift takes row r from column c+r, inverse from column c-r
    always_comb
    begin
        logic [1:0] src_f;
        logic [1:0] src_i;
        logic [6:0] pos_f;
        logic [6:0] pos_i;
        for (int r = 0; r < 4; r++)
        begin
            src_f = col + 2'(r);
            src_i = col - 2'(r);
            pos_f = {~src_f, 5'b0} + 7'(24 - 8 * r);
            pos_i = {~src_i, 5'b0} + 7'(24 - 8 * r);
            sb_fwd[31 - 8 * r -: 8] = sbox(state[pos_f +: 8]);
            sb_inv[31 - 8 * r -: 8] = inv_sbox(state[pos_i +: 8]);
        end
        own_col = state[{~col, 5'b0} +: 32];
    end

    always_comb
    begin
        unique case (kind)
            KIND_INIT: col_out = own_col ^ key_word;
            KIND_MID:  col_out = op ? inv_mix_col(sb_inv ^ key_word)
                                    : mix_col(sb_fwd) ^ key_word;
            KIND_LAST: col_out = (op ? sb_inv : sb_fwd) ^ key_word;
            default:   col_out = own_col ^ key_word;
        endcase
    end

endmodule

// ----- hdl/aes_key_exp.sv -----
module aes_key_exp (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   go,
    input  logic [1:0]             mode,
    input  logic [3:0][63:0]       key,
    output aes_pkg::key_wr_t       wr,
    output logic                   done
);
    import aes_pkg::*;

    logic             active_reg;
    logic             active_next;
    logic [RK_AW-1:0] idx_reg;
    logic [RK_AW-1:0] idx_next;
    logic [2:0]       mod_reg;
    logic [2:0]       mod_next;
    logic [7:0]       rcon_reg;
    logic [7:0]       rcon_next;
    logic [31:0]      win_reg [8];

    logic [3:0]       nk;
    logic [RK_AW-1:0] last_idx;
    logic [31:0]      word;
    logic [31:0]      back_word;
    logic [31:0]      t;
    logic [63:0]      key_pair;

    always_comb
    begin
        unique case (mode)
            MODE_128:
            begin
                nk        = 4'd4;
                last_idx  = RK_AW'(43);
                back_word = win_reg[3];
            end
            MODE_192:
            begin
                nk        = 4'd6;
                last_idx  = RK_AW'(51);
                back_word = win_reg[5];
            end
            default:
            begin
                nk        = 4'd8;
                last_idx  = RK_AW'(59);
                back_word = win_reg[7];
            end
        endcase
    end

    always_comb
    begin
        key_pair  = key[idx_reg[2:1]];
        t         = win_reg[0];
        rcon_next = rcon_reg;
        if (idx_reg < RK_AW'(nk))
        begin
            word = idx_reg[0] ? key_pair[31:0] : key_pair[63:32];
        end
        else
        begin
            if (mod_reg == 3'd0)
            begin
                t         = sub_word({win_reg[0][23:0], win_reg[0][31:24]}) ^ {rcon_reg, 24'h0};
                rcon_next = xt(rcon_reg);
            end
            else if (nk == 4'd8 && mod_reg == 3'd4)
            begin
                t = sub_word(win_reg[0]);
            end
            word = back_word ^ t;
        end
    end

    always_comb
    begin
        active_next = active_reg;
        idx_next    = idx_reg;
        mod_next    = mod_reg;
        done        = active_reg && idx_reg == last_idx;
        if (go)
        begin
            active_next = 1'b1;
            idx_next    = '0;
            mod_next    = '0;
        end
        else if (active_reg)
        begin
            idx_next = idx_reg + RK_AW'(1);
            mod_next = (4'(mod_reg) + 4'd1 == nk) ? 3'd0 : mod_reg + 3'd1;
            if (done)
            begin
                active_next = 1'b0;
            end
        end
    end

    assign wr.we   = active_reg;
    assign wr.addr = idx_reg;
    assign wr.data = word;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            active_reg <= 1'b0;
            idx_reg    <= '0;
            mod_reg    <= '0;
            rcon_reg   <= 8'h01;
        end
        else
        begin
            active_reg <= active_next;
            idx_reg    <= idx_next;
            mod_reg    <= mod_next;
            rcon_reg   <= go ? 8'h01 : (active_reg ? rcon_next : rcon_reg);
        end
    end

    always_ff @(posedge clk)
    begin
        if (active_reg)
        begin
            win_reg[0] <= word;
            for (int k = 1; k < 8; k++)
            begin
                win_reg[k] <= win_reg[k - 1];
            end
        end
    end

endmodule

// ----- tb/sv/testbench.sv -----
`timescale 1ns / 1ps

module testbench;
    import aes_pkg::*;

    typedef enum int {
        W_BLOCK,
        W_CFG,
        W_DRAIN
    } work_kind_t;

    typedef struct {
        work_kind_t  kind;
        logic [2:0]  idx;
        logic [63:0] data;
        logic        opv;
        logic [63:0] hi;
        logic [63:0] lo;
    } work_t;

    localparam logic OP_ENC = 1'b0;
    localparam logic OP_DEC = 1'b1;
    localparam logic [1:0] MODE_256 = 2'd2;
    localparam logic [1:0] MODE_ODD = 2'd3;
    localparam int CYCLE_LIMIT = 1000000;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        start = 1'b0;
    logic        op = 1'b0;
    logic [63:0] block_high = '0;
    logic [63:0] block_low = '0;
    logic        cfg_we = 1'b0;
    logic [2:0]  cfg_index = '0;
    logic [63:0] cfg_data = '0;
    logic        busy;
    logic        result_valid;
    logic [63:0] result_high;
    logic [63:0] result_low;

    aes_block_cipher DUT (
        .clk(clk),
        .rst_n(rst_n),
        .start(start),
        .busy(busy),
        .op(op),
        .block_high(block_high),
        .block_low(block_low),
        .result_valid(result_valid),
        .result_high(result_high),
        .result_low(result_low),
        .cfg_we(cfg_we),
        .cfg_index(cfg_index),
        .cfg_data(cfg_data)
    );

    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    // cipher model state
    logic [7:0]   sub_tab [256];
    logic [7:0]   unsub_tab [256];
    logic [31:0]  key_sched [60];
    logic         sched_ok = 1'b0;
    logic [1:0]   key_mode = MODE_128;
    logic [63:0]  key_regs [4] = '{default: '0};

    work_t        pending_work [$];
    logic [127:0] expected_blocks [$];
    int           errors = 0;
    int           cycles = 0;

    function automatic logic [7:0] gf_dbl(input logic [7:0] b);
        return {b[6:0], 1'b0} ^ (b[7] ? 8'h1B : 8'h00);
    endfunction

    function automatic logic [7:0] gf_mul(input logic [7:0] a, input logic [7:0] b);
        logic [7:0] acc;
        acc = 8'h00;
        for (int i = 0; i < 8; i++)
        begin
            if (b[i])
                acc ^= a;
            a = gf_dbl(a);
        end
        return acc;
    endfunction

    function automatic logic [7:0] rot8(input logic [7:0] x, input int n);
        return (x << n) | (x >> (8 - n));
    endfunction

    function automatic logic [7:0] forward_sub(input logic [7:0] x);
        logic [7:0] r;
        logic [7:0] p;
        r = 8'h01;
        p = x;
        // x^254 is the field inverse, zero stays zero
        for (int e = 254; e != 0; e >>= 1)
        begin
            if (e & 1)
                r = gf_mul(r, p);
            p = gf_mul(p, p);
        end
        return r ^ rot8(r, 1) ^ rot8(r, 2) ^ rot8(r, 3) ^ rot8(r, 4) ^ 8'h63;
    endfunction

    function automatic logic [31:0] sub_wd(input logic [31:0] w);
        return {sub_tab[w[31:24]], sub_tab[w[23:16]], sub_tab[w[15:8]], sub_tab[w[7:0]]};
    endfunction

    task automatic expand_schedule();
        int nk;
        int total;
        logic [7:0] rc;
        logic [31:0] t;
        nk = (key_mode == MODE_128) ? 4 : ((key_mode == MODE_192) ? 6 : 8);
        total = 4 * (nk + 7);
        rc = 8'h01;
        for (int i = 0; i < nk; i++)
            key_sched[i] = i[0] ? key_regs[(i >> 1) & 3][31:0] : key_regs[(i >> 1) & 3][63:32];
        for (int i = nk; i < total && i < 60; i++)
        begin
            t = key_sched[i - 1];
            if (i % nk == 0)
            begin
                t = sub_wd({t[23:0], t[31:24]}) ^ {rc, 24'h0};
                rc = gf_dbl(rc);
            end
            else if (nk > 6 && i % nk == 4)
                t = sub_wd(t);
            key_sched[i] = key_sched[i - nk] ^ t;
        end
        sched_ok = 1'b1;
    endtask

    function automatic logic [127:0] add_rk(input logic [127:0] st, input int rnd);
        logic [31:0] w;
        for (int c = 0; c < 4; c++)
        begin
            w = key_sched[(4 * rnd + c) % 60];
            st[127 - 32 * c -: 32] ^= w;
        end
        return st;
    endfunction

    function automatic logic [127:0] subst(input logic [127:0] st, input logic inv);
        for (int i = 0; i < 16; i++)
            st[127 - 8 * i -: 8] = inv ? unsub_tab[st[127 - 8 * i -: 8]]
                                       : sub_tab[st[127 - 8 * i -: 8]];
        return st;
    endfunction

    function automatic logic [127:0] shift(input logic [127:0] st, input logic inv);
        logic [127:0] t;
        int src;
        int dst;
        for (int c = 0; c < 4; c++)
            for (int r = 0; r < 4; r++)
            begin
                src = inv ? c * 4 + r : ((c + r) & 3) * 4 + r;
                dst = inv ? ((c + r) & 3) * 4 + r : c * 4 + r;
                t[127 - 8 * dst -: 8] = st[127 - 8 * src -: 8];
            end
        return t;
    endfunction

    function automatic logic [127:0] mix(input logic [127:0] st, input logic inv);
        logic [7:0] m [4];
        logic [7:0] acc;
        logic [127:0] t;
        if (inv)
            m = '{8'h0E, 8'h0B, 8'h0D, 8'h09};
        else
            m = '{8'h02, 8'h03, 8'h01, 8'h01};
        for (int c = 0; c < 4; c++)
            for (int r = 0; r < 4; r++)
            begin
                acc = 8'h00;
                for (int k = 0; k < 4; k++)
                    acc ^= gf_mul(st[127 - 8 * (c * 4 + k) -: 8], m[(k + 4 - r) & 3]);
                t[127 - 8 * (c * 4 + r) -: 8] = acc;
            end
        return t;
    endfunction

    task automatic predict_block(input logic dec, input logic [63:0] hi, input logic [63:0] lo);
        logic [127:0] st;
        int nr;
        if (!sched_ok)
            expand_schedule();
        nr = (key_mode == MODE_128) ? 10 : ((key_mode == MODE_192) ? 12 : 14);
        st = {hi, lo};
        if (dec == OP_ENC)
        begin
            st = add_rk(st, 0);
            for (int rnd = 1; rnd < nr; rnd++)
                st = add_rk(mix(shift(subst(st, 0), 0), 0), rnd);
            st = add_rk(shift(subst(st, 0), 0), nr);
        end
        else
        begin
            st = add_rk(st, nr);
            for (int rnd = nr - 1; rnd > 0; rnd--)
                st = mix(add_rk(subst(shift(st, 1), 1), rnd), 1);
            st = add_rk(subst(shift(st, 1), 1), 0);
        end
        expected_blocks = {expected_blocks, st};
    endtask

    task automatic apply_cfg(input logic [2:0] idx, input logic [63:0] v);
        if (idx == CFG_KEY_MODE)
        begin
            key_mode = v[1:0];
            sched_ok = 1'b0;
        end
        else if (idx <= CFG_KEY_3)
        begin
            key_regs[idx - 1] = v;
            sched_ok = 1'b0;
        end
    endtask

    // driver
    int burst_left = 4;
    int gap_left = 0;
    int quiet = 0;
    always @(posedge clk)
    begin
        logic holding;
        logic nxt_start;
        logic nxt_we;
        work_t w;
        if (rst_n)
        begin
            holding = 1'b0;
            nxt_start = 1'b0;
            nxt_we = 1'b0;
            if (start && !busy)
                predict_block(op, block_high, block_low);
            else
                holding = start;
            if (holding)
                nxt_start = 1'b1;
            else if (gap_left > 0)
                gap_left--;
            else if (pending_work.size() > 0)
            begin
                w = pending_work[0];
                if (w.kind == W_BLOCK)
                begin
                    void'(pending_work.pop_front());
                    nxt_start = 1'b1;
                    op <= w.opv;
                    block_high <= w.hi;
                    block_low <= w.lo;
                    burst_left--;
                    if (burst_left <= 0)
                    begin
                        burst_left = $urandom_range(1, 24);
                        gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 60);
                    end
                end
                else if (expected_blocks.size() == 0 && !busy && !start && !cfg_we)
                begin
                    quiet++;
                    if (quiet >= 8)
                    begin
                        quiet = 0;
                        void'(pending_work.pop_front());
                        if (w.kind == W_CFG)
                        begin
                            nxt_we = 1'b1;
                            cfg_index <= w.idx;
                            cfg_data <= w.data;
                            apply_cfg(w.idx, w.data);
                        end
                    end
                end
                else
                    quiet = 0;
            end
            start <= nxt_start;
            cfg_we <= nxt_we;
        end
    end

    // monitor
    always @(posedge clk)
    begin
        logic [127:0] want;
        if (rst_n && result_valid)
        begin
            if (expected_blocks.size() == 0)
            begin
                $display("%0t: unexpected result word %h %h", $time, result_high, result_low);
                errors++;
            end
            else
            begin
                want = expected_blocks.pop_front();
                if (result_high !== want[127:64])
                begin
                    $display("%0t: result_high expected %h actual %h",
                             $time, want[127:64], result_high);
                    errors++;
                end
                if (result_low !== want[63:0])
                begin
                    $display("%0t: result_low expected %h actual %h",
                             $time, want[63:0], result_low);
                    errors++;
                end
            end
        end
    end

    always @(posedge clk)
    begin
        cycles++;
        if (cycles >= CYCLE_LIMIT)
        begin
            $display("Simulation FAILED");
            $finish;
        end
    end

    function automatic logic [63:0] rand64();
        return {$urandom, $urandom};
    endfunction

    function automatic logic [63:0] pick64();
        case ($urandom_range(0, 9))
            0: return '0;
            1: return '1;
            2: return 64'h8000_0000_0000_0001;
            default: return rand64();
        endcase
    endfunction

    task automatic add_block(input logic d, input logic [63:0] hi, input logic [63:0] lo);
        work_t w;
        w.kind = W_BLOCK;
        w.opv = d;
        w.hi = hi;
        w.lo = lo;
        pending_work = {pending_work, w};
    endtask

    task automatic add_cfg(input logic [2:0] idx, input logic [63:0] v);
        work_t w;
        w.kind = W_CFG;
        w.idx = idx;
        w.data = v;
        pending_work = {pending_work, w};
    endtask

    task automatic add_drain();
        work_t w;
        w.kind = W_DRAIN;
        pending_work = {pending_work, w};
    endtask

    task automatic add_key(input logic [1:0] mode, input logic [63:0] k0, input logic [63:0] k1,
                           input logic [63:0] k2, input logic [63:0] k3);
        add_cfg(CFG_KEY_0, k0);
        add_cfg(CFG_KEY_1, k1);
        add_cfg(CFG_KEY_2, k2);
        add_cfg(CFG_KEY_3, k3);
        // upper data bits are ignored by the mode register
        add_cfg(CFG_KEY_MODE, (rand64() & ~64'h3) | 64'(mode));
    endtask

    initial
    begin
        logic [1:0] mode;
        for (int i = 0; i < 256; i++)
            sub_tab[i] = forward_sub(i[7:0]);
        for (int i = 0; i < 256; i++)
            unsub_tab[sub_tab[i]] = i[7:0];

        // reset key, then textbook vectors and extremes
        add_block(OP_ENC, '0, '0);
        add_block(OP_DEC, '0, '0);
        add_block(OP_ENC, '1, '1);
        add_block(OP_DEC, '1, '1);
        add_key(MODE_128, 64'h0001020304050607, 64'h08090a0b0c0d0e0f, '1, '1);
        add_block(OP_ENC, 64'h0011223344556677, 64'h8899aabbccddeeff);
        add_block(OP_DEC, 64'h69c4e0d86a7b0430, 64'hd8cdb78070b4c55a);
        add_key(MODE_192, 64'h0001020304050607, 64'h08090a0b0c0d0e0f,
                64'h1011121314151617, '1);
        add_block(OP_ENC, 64'h0011223344556677, 64'h8899aabbccddeeff);
        add_block(OP_DEC, 64'hdda97ca4864cdfe0, 64'h6eaf70a0ec0d7191);
        add_key(MODE_256, 64'h0001020304050607, 64'h08090a0b0c0d0e0f,
                64'h1011121314151617, 64'h18191a1b1c1d1e1f);
        add_block(OP_ENC, 64'h0011223344556677, 64'h8899aabbccddeeff);
        add_block(OP_DEC, 64'h8ea2b7ca516745bf, 64'heafc49904b496089);
        // mode 3 runs as the 256-bit key
        add_cfg(CFG_KEY_MODE, 64'(MODE_ODD));
        add_block(OP_ENC, '1, '0);
        add_block(OP_DEC, '0, '1);
        add_key(MODE_256, '1, '1, '1, '1);
        add_block(OP_ENC, '0, '1);
        add_block(OP_DEC, 64'h5555555555555555, 64'haaaaaaaaaaaaaaaa);
        // writes to unmapped indexes leave the schedule alone
        add_cfg(3'd5, rand64());
        add_cfg(3'd7, rand64());
        add_block(OP_ENC, 64'h0123456789abcdef, 64'hfedcba9876543210);

        for (int ph = 0; ph < 16; ph++)
        begin
            mode = (ph < 4) ? ph[1:0] : 2'($urandom_range(0, 3));
            if (ph == 4)
                add_key(mode, '0, '0, '0, '0);
            else
                add_key(mode, pick64(), pick64(), pick64(), pick64());
            if ($urandom_range(0, 2) == 0)
                add_cfg(3'($urandom_range(5, 7)), rand64());
            for (int n = 0; n < 50; n++)
            begin
                add_block(1'($urandom_range(0, 1)), pick64(), pick64());
                if ($urandom_range(0, 60) == 0)
                    add_drain();
            end
            add_drain();
        end

        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        while (pending_work.size() != 0 || start || expected_blocks.size() != 0)
            @(posedge clk);
        repeat (100) @(posedge clk);
        if (errors == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

endmodule
